// File: rtl/core/crbf_pkg.sv
// Shared types, constants and small lookup functions for the compact RBF
// weight evaluator. No dependencies; imported by every rtl/core module but crbf_check.
package crbf_pkg;

    // Input fixed point format (fraction bits of dist_sq and cutoff_sq)
    localparam int IN_FRAC_BITS = 16;

    // Kernel mode codes
    localparam logic [1:0] KM_GAUSS = 2'd0;
    localparam logic [1:0] KM_WEND  = 2'd1;
    localparam logic [1:0] KM_CONST = 2'd2;
    localparam logic [1:0] KM_RESET = KM_WEND;

    // Register map, selected by paddr[2]
    localparam logic REG_KERNEL_MODE = 1'b0;

    // Pipeline depths (register stages per unit)
    localparam int DIV_STAGES   = 33;
    localparam int SQRT_STAGES  = 31;
    localparam int POLY_STAGES  = 7;
    localparam int EXP_TERMS    = 14;
    localparam int TERM_STAGES  = 2 * EXP_TERMS;
    localparam int GAUSS_FRONT  = 4;
    localparam int GAUSS_STAGES = GAUSS_FRONT + TERM_STAGES + 1;
    localparam int PIPE_DEPTH   = DIV_STAGES + SQRT_STAGES + POLY_STAGES;
    localparam int GAUSS_DELAY  = PIPE_DEPTH - GAUSS_STAGES;

    // Gaussian constants
    localparam logic [8:0]  DECAY_SQ  = 9'd400;
    localparam int          GX_W      = 5 + IN_FRAC_BITS;   // X below 32.0
    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [63:0] GK_WIDE   = (64'd1 << 38) / 64'hB172_17F8;
    localparam logic [6:0]  GAUSS_K   = GK_WIDE[6:0];       // 64 / ln2 = 2^38 / LN2_Q32
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [31:0] ONE_Q28   = 32'h1000_0000;

    typedef struct packed {
        logic bad;       // zero cutoff
        logic outside;   // dist_sq above cutoff_sq
    } t_side;

    // Rounded-up reciprocal of k, exact floor(v/k) for any 32-bit v
    function automatic logic [32:0] exp_recip(input int k);
        logic [32:0] m;
        case (k)
            3, 6, 12: m = 33'h1_5555_5556;
            5, 10:    m = 33'h1_9999_999A;
            7, 14:    m = 33'h1_2492_4925;
            9:        m = 33'h1_C71C_71C8;
            11:       m = 33'h1_745D_1746;
            13:       m = 33'h1_3B13_B13C;
            default:  m = 33'h1_0000_0000;
        endcase
        return m;
    endfunction

    function automatic int exp_shift(input int k);
        int s;
        if (k <= 1)      s = 32;
        else if (k <= 2) s = 33;
        else if (k <= 4) s = 34;
        else if (k <= 8) s = 35;
        else             s = 36;
        return s;
    endfunction

    // Wendland Horner coefficients after the leading 5
    function automatic logic [7:0] poly_coef(input int k);
        logic [7:0] c;
        case (k)
            0:       c = 8'd30;
            1:       c = 8'd72;
            2:       c = 8'd82;
            3:       c = 8'd36;
            default: c = 8'd6;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/crbf_div.sv
// Pipelined restoring divider, one quotient bit per stage: (num << 32) / den.
// Depends on crbf_pkg. Valid for num <= den; other cases are masked later.
module crbf_div import crbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_vld,
    output logic [32:0] o_quo
);

    logic        r_vld [DIV_STAGES];
    logic [31:0] r_rem [DIV_STAGES];
    logic [31:0] r_den [DIV_STAGES];
    logic [32:0] r_quo [DIV_STAGES];

    logic [31:0] n_rem [DIV_STAGES];
    logic [32:0] n_quo [DIV_STAGES];
    logic [31:0] w_den [DIV_STAGES];
    logic [32:0] w_sh  [DIV_STAGES];
    logic [32:0] w_dif [DIV_STAGES];
    logic [32:0] w_qin [DIV_STAGES];
    logic        w_ge  [DIV_STAGES];

    always_comb begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                w_sh[s]  = {1'b0, i_num};
                w_den[s] = i_den;
                w_qin[s] = '0;
            end else begin
                w_sh[s]  = {r_rem[s-1], 1'b0};
                w_den[s] = r_den[s-1];
                w_qin[s] = r_quo[s-1];
            end
            w_ge[s]  = w_sh[s] >= {1'b0, w_den[s]};
            w_dif[s] = w_sh[s] - {1'b0, w_den[s]};
            n_rem[s] = w_ge[s] ? w_dif[s][31:0] : w_sh[s][31:0];
            n_quo[s] = {w_qin[s][31:0], w_ge[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < DIV_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_den[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

// File: rtl/core/crbf_sqrt.sv
// Pipelined integer square root of (q << 28), one root bit per stage.
// Depends on crbf_pkg. Root is t = r/rho in Q0.30.
module crbf_sqrt import crbf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [32:0]            i_q,
    output logic                   o_vld,
    output logic [SQRT_STAGES-1:0] o_root
);

    logic        r_vld [SQRT_STAGES];
    logic [61:0] r_rem [SQRT_STAGES];
    logic [61:0] r_res [SQRT_STAGES];

    logic [61:0] w_rem [SQRT_STAGES];
    logic [61:0] w_res [SQRT_STAGES];
    logic [61:0] w_bit [SQRT_STAGES];
    logic [61:0] w_try [SQRT_STAGES];
    logic [61:0] n_rem [SQRT_STAGES];
    logic [61:0] n_res [SQRT_STAGES];
    logic        w_ge  [SQRT_STAGES];

    always_comb begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                w_rem[s] = {1'b0, i_q, 28'b0};
                w_res[s] = '0;
            end else begin
                w_rem[s] = r_rem[s-1];
                w_res[s] = r_res[s-1];
            end
            w_bit[s] = 62'd1 << (2 * (SQRT_STAGES - 1 - s));
            w_try[s] = w_res[s] + w_bit[s];
            w_ge[s]  = w_rem[s] >= w_try[s];
            n_rem[s] = w_ge[s] ? w_rem[s] - w_try[s] : w_rem[s];
            n_res[s] = w_ge[s] ? (w_res[s] >> 1) + w_bit[s] : (w_res[s] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SQRT_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < SQRT_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_res[s] <= n_res[s];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_res[SQRT_STAGES-1][SQRT_STAGES-1:0];

endmodule

// File: rtl/core/crbf_poly.sv
// Wendland C4 kernel from t: Horner polynomial in Q.24 and (1-t)^6 in Q0.30,
// then the final product rounded to Q4.28. Depends on crbf_pkg.
module crbf_poly import crbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [30:0] i_t,
    output logic        o_vld,
    output logic [31:0] o_w
);

    localparam logic [31:0] P_LEAD = 32'd5 << 24;

    logic        r_vld [POLY_STAGES];
    logic [31:0] r_p   [5];
    logic [30:0] r_t   [4];
    logic [30:0] r_u, r_u2, r_u3, r_u6;
    logic [30:0] r_u6d [2];
    logic [62:0] r_prod;
    logic [31:0] r_w;

    logic [31:0] w_psrc [5];
    logic [30:0] w_tsrc [5];
    logic [62:0] w_pmul [5];
    logic [31:0] n_p    [5];
    logic [30:0] w_u;
    logic [61:0] w_uu, w_u2u, w_u33;
    logic [63:0] w_rnd;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            w_psrc[k] = (k == 0) ? P_LEAD : r_p[(k == 0) ? 0 : k - 1];
            w_tsrc[k] = (k == 0) ? i_t : r_t[(k == 0) ? 0 : k - 1];
            w_pmul[k] = 63'(w_psrc[k]) * 63'(w_tsrc[k]);
            n_p[k]    = w_pmul[k][61:30] + {poly_coef(k), 24'b0};
        end
        w_u   = 31'h4000_0000 - i_t;
        w_uu  = 62'(w_u) * 62'(w_u);
        w_u2u = 62'(r_u2) * 62'(r_u);
        w_u33 = 62'(r_u3) * 62'(r_u3);
        w_rnd = {1'b0, r_prod} + 64'h200_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < POLY_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < POLY_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 5; k++) r_p[k] <= n_p[k];
            r_t[0] <= i_t;
            for (int k = 1; k < 4; k++) r_t[k] <= r_t[k-1];
            r_u      <= w_u;
            r_u2     <= w_uu[60:30];
            r_u3     <= w_u2u[60:30];
            r_u6     <= w_u33[60:30];
            r_u6d[0] <= r_u6;
            r_u6d[1] <= r_u6d[0];
            r_prod   <= 63'(r_p[4]) * 63'(r_u6d[1]);
            r_w      <= w_rnd[57:26];
        end
    end

    assign o_vld = r_vld[POLY_STAGES-1];
    assign o_w   = r_w;

endmodule

// File: rtl/core/crbf_gauss.sv
// Compact Gaussian exp(-400*r_sq): range reduction by ln2, a 14-term Horner
// series with reciprocal-multiply division, final scale shift. Uses crbf_pkg.
module crbf_gauss import crbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_dist,
    output logic        o_vld,
    output logic [31:0] o_w
);

    localparam int PW = GX_W + 7;

    logic              r_vld [GAUSS_STAGES];

    // range reduction front
    logic [GX_W-1:0]   r_f0_x, r_f1_x, r_f2_x;
    logic              r_f0_big, r_f1_big, r_f2_big, r_f3_big;
    logic [PW-1:0]     r_f1_prod;
    logic [5:0]        r_f2_n, r_f3_n;
    logic [37:0]       r_f2_nl;
    logic [31:0]       r_f3_g;

    // series stages: even stage holds (g*p)>>32, odd stage holds v*recip
    logic [64:0]       r_td   [TERM_STAGES];
    logic [31:0]       r_tg   [TERM_STAGES];
    logic [5:0]        r_tn   [TERM_STAGES];
    logic              r_tbig [TERM_STAGES];
    logic [31:0]       r_w;

    logic [40:0]       w_x;
    logic [5:0]        w_nest;
    logic [37:0]       w_xq, w_g0, w_g1;
    logic              w_fix;
    logic [31:0]       w_gsrc [TERM_STAGES];
    logic [5:0]        w_nsrc [TERM_STAGES];
    logic              w_bsrc [TERM_STAGES];
    logic [64:0]       w_q    [TERM_STAGES];
    logic [32:0]       w_p    [TERM_STAGES];
    logic [64:0]       w_mul  [TERM_STAGES];
    logic [64:0]       n_td   [TERM_STAGES];
    logic [64:0]       w_qf;
    logic [32:0]       w_e;
    logic [6:0]        w_sh;
    logic [51:0]       w_sum, w_scl;

    always_comb begin
        w_x    = 41'(i_dist) * 41'(DECAY_SQ);
        w_nest = r_f1_prod[PW-1:PW-6];
        w_xq   = 38'(r_f2_x) << (32 - IN_FRAC_BITS);
        w_g0   = w_xq - r_f2_nl;
        w_fix  = w_g0 >= 38'(LN2_Q32);
        w_g1   = w_fix ? w_g0 - 38'(LN2_Q32) : w_g0;

        for (int m = 0; m < TERM_STAGES; m++) begin
            if (m == 0) begin
                w_gsrc[m] = r_f3_g;
                w_nsrc[m] = r_f3_n;
                w_bsrc[m] = r_f3_big;
                w_q[m]    = '0;
                w_p[m]    = ONE_Q32;
            end else begin
                w_gsrc[m] = r_tg[m-1];
                w_nsrc[m] = r_tn[m-1];
                w_bsrc[m] = r_tbig[m-1];
                w_q[m]    = r_td[m-1] >> exp_shift(EXP_TERMS - (m >> 1) + 1);
                w_p[m]    = ONE_Q32 - w_q[m][32:0];
            end
            if ((m & 1) == 0) begin
                w_mul[m] = 65'(w_gsrc[m]) * 65'(w_p[m]);
                n_td[m]  = {33'b0, w_mul[m][63:32]};
            end else begin
                w_mul[m] = 65'(r_td[m-1][31:0]) * 65'(exp_recip(EXP_TERMS - (m >> 1)));
                n_td[m]  = w_mul[m];
            end
        end

        // last term divides by 1: quotient is the top of the product
        w_qf  = r_td[TERM_STAGES-1] >> exp_shift(1);
        w_e   = ONE_Q32 - w_qf[32:0];
        w_sh  = {1'b0, r_tn[TERM_STAGES-1]} + 7'd3;
        w_sum = 52'(w_e) + (52'd1 << w_sh);
        w_scl = w_sum >> (w_sh + 7'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < GAUSS_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < GAUSS_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f0_x    <= w_x[GX_W-1:0];
            r_f0_big  <= |w_x[40:GX_W];
            r_f1_x    <= r_f0_x;
            r_f1_big  <= r_f0_big;
            r_f1_prod <= PW'(r_f0_x) * PW'(GAUSS_K);
            r_f2_x    <= r_f1_x;
            r_f2_big  <= r_f1_big;
            r_f2_n    <= w_nest;
            r_f2_nl   <= 38'(w_nest) * 38'(LN2_Q32);
            r_f3_g    <= w_g1[31:0];
            r_f3_n    <= r_f2_n + 6'(w_fix);
            r_f3_big  <= r_f2_big;
            for (int m = 0; m < TERM_STAGES; m++) begin
                r_td[m]   <= n_td[m];
                r_tg[m]   <= w_gsrc[m];
                r_tn[m]   <= w_nsrc[m];
                r_tbig[m] <= w_bsrc[m];
            end
            r_w <= r_tbig[TERM_STAGES-1] ? 32'd0 : w_scl[31:0];
        end
    end

    assign o_vld = r_vld[GAUSS_STAGES-1];
    assign o_w   = r_w;

endmodule

// File: rtl/core/compact_rbf_weight_eval.sv
// Top level of the compact RBF weight evaluator: stream ports, mode register,
// Wendland and Gaussian pipelines, result select and output skid stage.
// Depends on crbf_pkg, crbf_div, crbf_sqrt, crbf_poly, crbf_gauss.
//
//  channel  | signals                        | payload
//  ---------+--------------------------------+---------------------------------
//  s_axis   | tvalid, tready, tdata[63:0]    | dist_sq, cutoff_sq
//  m_axis   | tvalid, tready, tdata, tuser   | weight; bad_cutoff
//  apb      | psel, penable, pwrite, paddr.. | kernel_mode at 0x0
//
// One request per cycle while s_axis_tready is high. Each result passes
// through the 33-stage divider, the 31-stage square root and the 7-stage
// Wendland polynomial; the Gaussian unit is shorter and is delayed.
// The whole pipeline shares one advance enable. A one-entry skid behind the
// output register absorbs a stall; s_axis_tready drops only while it is full.
// Synchronous active-low reset clears valid state and sets kernel_mode to 1.
module compact_rbf_weight_eval import crbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] dist_sq, [63:32] cutoff_sq
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] weight
    output logic [0:0]  m_axis_tuser,   // [0] bad_cutoff
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_mode;
    logic        en;
    logic        in_vld;
    logic [31:0] in_dist, in_cut;

    logic        div_vld, sqrt_vld, poly_vld, gauss_vld;
    logic [32:0] div_quo;
    logic [30:0] sqrt_t;
    logic [31:0] poly_w, gauss_w;

    t_side       r_sb [PIPE_DEPTH];
    logic [31:0] r_gd [GAUSS_DELAY];

    logic [31:0] pipe_w;
    logic        pipe_bad;

    logic        r_ovld, r_obad, r_svld, r_sbad;
    logic [31:0] r_ow, r_sw;

    // ---- configuration ----
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KERNEL_MODE) ? {30'b0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= KM_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_KERNEL_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    // ---- pipeline ----
    assign en            = ~r_svld;
    assign s_axis_tready = en;
    assign in_vld        = s_axis_tvalid;
    assign in_dist       = s_axis_tdata[31:0];
    assign in_cut        = s_axis_tdata[63:32];

    crbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_vld),
        .i_num   (in_dist),
        .i_den   (in_cut),
        .o_vld   (div_vld),
        .o_quo   (div_quo)
    );

    crbf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_q     (div_quo),
        .o_vld   (sqrt_vld),
        .o_root  (sqrt_t)
    );

    crbf_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sqrt_vld),
        .i_t     (sqrt_t),
        .o_vld   (poly_vld),
        .o_w     (poly_w)
    );

    crbf_gauss u_gauss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_vld),
        .i_dist  (in_dist),
        .o_vld   (gauss_vld),
        .o_w     (gauss_w)
    );

    // sideband flags and delayed Gaussian weight ride alongside
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0].bad     <= (in_cut == 32'd0);
            r_sb[0].outside <= (in_dist > in_cut);
            for (int s = 1; s < PIPE_DEPTH; s++) r_sb[s] <= r_sb[s-1];
            r_gd[0] <= gauss_vld ? gauss_w : 32'd0;
            for (int s = 1; s < GAUSS_DELAY; s++) r_gd[s] <= r_gd[s-1];
        end
    end

    always_comb begin
        case (r_mode)
            KM_GAUSS: pipe_w = r_gd[GAUSS_DELAY-1];
            KM_WEND:  pipe_w = poly_w;
            KM_CONST: pipe_w = ONE_Q28;
            default:  pipe_w = 32'd0;
        endcase
        if (r_sb[PIPE_DEPTH-1].bad || r_sb[PIPE_DEPTH-1].outside) begin
            pipe_w = 32'd0;
        end
        pipe_bad = r_sb[PIPE_DEPTH-1].bad;
    end

    // ---- output register and skid ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (r_svld) begin
            if (m_axis_tready) begin
                r_ovld <= 1'b1;
                r_svld <= 1'b0;
            end
        end else if (!r_ovld || m_axis_tready) begin
            r_ovld <= poly_vld;
        end else if (poly_vld) begin
            r_svld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_svld) begin
            if (m_axis_tready) begin
                r_ow   <= r_sw;
                r_obad <= r_sbad;
            end
        end else if (!r_ovld || m_axis_tready) begin
            r_ow   <= pipe_w;
            r_obad <= pipe_bad;
        end else begin
            r_sw   <= pipe_w;
            r_sbad <= pipe_bad;
        end
    end

    assign m_axis_tvalid   = r_ovld;
    assign m_axis_tdata    = r_ow;
    assign m_axis_tuser[0] = r_obad;

endmodule

// File: rtl/core/crbf_check.sv
// Port-level checks for compact_rbf_weight_eval, attached by bind.
// Depends on nothing but the top-level port list.
module crbf_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // a zero cutoff always yields a zero weight
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("bad_cutoff with nonzero weight");

    // every kernel stays at or below 6.0 in Q4.28, so the top bit stays clear
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31])
        else $error("weight above kernel range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result withdrawn without handshake");

endmodule

bind compact_rbf_weight_eval crbf_check u_crbf_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
